>>> sv/packbits_rle_decoder_unit_assert.svh
// assertion helpers for the packbits decoder, sampled on clk, off during reset
`ifndef PACKBITS_RLE_DECODER_UNIT_ASSERT_SVH
`define PACKBITS_RLE_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define PBRLE_ASSERT_IMPL(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define PBRLE_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> sv/pbrle_pkg.sv
package pbrle_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_ELEMENT_BYTES = 2'd0;
    localparam logic [1:0] REG_LINE_ELEMENTS = 2'd1;

    localparam logic [1:0]  ELEMENT_BYTES_RESET = 2'd1;
    localparam logic [15:0] LINE_ELEMENTS_RESET = 16'd256;

    // header code that is skipped
    localparam logic [7:0] HDR_NOP = 8'h80;

    // controller to datapath
    typedef struct packed {
        logic hdr_load;   // accept a run header
        logic hdr_err;    // header overruns the line, emit error beat
        logic lit_byte;   // literal data byte, emit one-byte beat
        logic rep_byte;   // repeat value byte
        logic chunk;      // emit one chunk of a repeat burst
    } pbrle_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;     // output register can load this cycle
        logic hdr_nop;      // input byte is the skip header
        logic hdr_over;     // run of the input header exceeds the line
        logic hdr_literal;  // input header starts a literal run
        logic last_byte;    // one byte left in the run or value
        logic last_chunk;   // remaining burst fits in one beat
    } pbrle_status_t;

endpackage

>>> sv/pbrle_ctrl.sv
module pbrle_ctrl
    import pbrle_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pbrle_status_t status,
    output pbrle_cmd_t    cmd
);

    localparam logic [1:0] ST_HEADER  = 2'd0;
    localparam logic [1:0] ST_LITERAL = 2'd1;
    localparam logic [1:0] ST_REPEAT  = 2'd2;
    localparam logic [1:0] ST_BURST   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_HEADER:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free && !status.hdr_nop)
                begin
                    if (status.hdr_over)
                    begin
                        cmd.hdr_err = 1'b1;
                    end
                    else
                    begin
                        cmd.hdr_load = 1'b1;
                        state_next   = status.hdr_literal ? ST_LITERAL : ST_REPEAT;
                    end
                end
            end
            ST_LITERAL:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    cmd.lit_byte = 1'b1;
                    if (status.last_byte)
                    begin
                        state_next = ST_HEADER;
                    end
                end
            end
            ST_REPEAT:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    cmd.rep_byte = 1'b1;
                    if (status.last_byte)
                    begin
                        state_next = ST_BURST;
                    end
                end
            end
            ST_BURST:
            begin
                if (status.out_free)
                begin
                    cmd.chunk = 1'b1;
                    if (status.last_chunk)
                    begin
                        state_next = ST_HEADER;
                    end
                end
            end
            default:
            begin
                state_next = ST_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/pbrle_datapath.sv
`include "packbits_rle_decoder_unit_assert.svh"

module pbrle_datapath
    import pbrle_pkg::*;
#(
    parameter int OUT_BYTES = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    in_byte,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    input  pbrle_cmd_t    cmd,
    output pbrle_status_t status,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [63:0]   out_data,
    output logic [3:0]    byte_count,
    output logic          run_last,
    output logic          line_done,
    output logic          overrun_error
);

    localparam logic [8:0] OB9 = 9'(OUT_BYTES);
    localparam logic [3:0] OB4 = 4'(OUT_BYTES);

    logic [1:0]  eb_cfg_reg, eb_cfg_next;
    logic [15:0] line_cfg_reg, line_cfg_next;
    logic [7:0]  run_reg, run_next;
    logic [8:0]  left_reg, left_next;
    logic [7:0]  fvb_reg, fvb_next;
    logic [7:0]  val_reg, val_next;
    logic [15:0] done_reg, done_next;
    logic [8:0]  rem_reg, rem_next;
    logic        par_reg, par_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] data_reg, data_next;
    logic [3:0]  count_reg, count_next;
    logic        last_reg, last_next;
    logic        line_reg, line_next;
    logic        err_reg, err_next;

    logic        eb2;
    logic [16:0] line_len;
    logic [16:0] room;
    logic [7:0]  nb;
    logic [8:0]  left_dec;
    logic        lit_elem;
    logic [3:0]  chunk_len;
    logic [4:0]  half_sum;
    logic [3:0]  chunk_elems;
    logic [63:0] chunk_data;
    logic [3:0]  elem_add;
    logic [16:0] count_res;
    logic        out_free;

    // advance the element count by k elements, k at most eight;
    // returns line-end flag and the new count
    function automatic logic [16:0] count_step(input logic [15:0] d, input logic [3:0] k,
                                               input logic [16:0] len);
        logic [16:0] sum;
        logic        flag;
        logic [15:0] nd;
        logic [6:0]  t;
        logic [6:0]  l7;
        sum  = {1'b0, d} + {13'b0, k};
        flag = (sum >= len);
        l7   = {4'b0, len[2:0]};
        t    = {2'b0, sum[4:0]};
        if (len[16:3] != 14'd0)
        begin
            nd = flag ? 16'(sum - len) : sum[15:0];
        end
        else
        begin
            // short lines can wrap several times within one beat
            if (t >= (l7 << 3)) t = t - (l7 << 3);
            if (t >= (l7 << 2)) t = t - (l7 << 2);
            if (t >= (l7 << 1)) t = t - (l7 << 1);
            if (t >= l7)        t = t - l7;
            nd = {9'b0, t};
        end
        return {flag, nd};
    endfunction

    assign eb2      = eb_cfg_reg[1];
    assign line_len = (line_cfg_reg == 16'd0) ? 17'h10000 : {1'b0, line_cfg_reg};
    assign room     = line_len - {1'b0, done_reg};
    assign nb       = in_byte[7] ? 8'(9'd257 - {1'b0, in_byte}) : (in_byte + 8'd1);
    assign left_dec = left_reg - 9'd1;
    assign lit_elem = !eb2 || !left_dec[0];

    assign chunk_len   = (rem_reg <= OB9) ? rem_reg[3:0] : OB4;
    assign half_sum    = {1'b0, chunk_len} + {4'b0, par_reg};
    assign chunk_elems = eb2 ? half_sum[4:1] : chunk_len;

    always_comb
    begin
        chunk_data = '0;
        for (int j = 0; j < OUT_BYTES; j++)
        begin
            if (4'(j) < chunk_len)
            begin
                chunk_data[8*j +: 8] = (eb2 && (par_reg == 1'(j))) ? fvb_reg : val_reg;
            end
        end
    end

    assign elem_add  = cmd.chunk ? chunk_elems :
                       (cmd.lit_byte && lit_elem) ? 4'd1 : 4'd0;
    assign count_res = count_step(done_reg, elem_add, line_len);

    assign out_free = !out_valid_reg || out_ready;

    assign status.out_free    = out_free;
    assign status.hdr_nop     = (in_byte == HDR_NOP);
    assign status.hdr_over    = ({9'b0, nb} > room);
    assign status.hdr_literal = !in_byte[7];
    assign status.last_byte   = (left_reg == 9'd1);
    assign status.last_chunk  = (rem_reg <= OB9);

    always_comb
    begin
        eb_cfg_next    = eb_cfg_reg;
        line_cfg_next  = line_cfg_reg;
        run_next       = run_reg;
        left_next      = left_reg;
        fvb_next       = fvb_reg;
        val_next       = val_reg;
        done_next      = done_reg;
        rem_next       = rem_reg;
        par_next       = par_reg;
        out_valid_next = out_valid_reg && !out_ready;
        data_next      = data_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        line_next      = line_reg;
        err_next       = err_reg;

        if (cfg_we)
        begin
            if (cfg_index == REG_ELEMENT_BYTES)
            begin
                eb_cfg_next = cfg_data[1:0];
            end
            else if (cfg_index == REG_LINE_ELEMENTS)
            begin
                line_cfg_next = cfg_data;
                done_next     = 16'd0;
            end
        end

        if (cmd.hdr_load)
        begin
            run_next = nb;
            if (in_byte[7])
                left_next = eb2 ? 9'd2 : 9'd1;
            else
                left_next = eb2 ? {nb, 1'b0} : {1'b0, nb};
        end

        if (cmd.hdr_err)
        begin
            out_valid_next = 1'b1;
            data_next      = '0;
            count_next     = 4'd0;
            last_next      = 1'b1;
            line_next      = 1'b0;
            err_next       = 1'b1;
        end

        if (cmd.lit_byte)
        begin
            left_next      = left_dec;
            done_next      = count_res[15:0];
            out_valid_next = 1'b1;
            data_next      = {56'b0, in_byte};
            count_next     = 4'd1;
            last_next      = 1'b1;
            line_next      = count_res[16];
            err_next       = 1'b0;
        end

        if (cmd.rep_byte)
        begin
            left_next = left_dec;
            if (left_dec != 9'd0)
            begin
                fvb_next = in_byte;
            end
            else
            begin
                val_next = in_byte;
                rem_next = eb2 ? {run_reg, 1'b0} : {1'b0, run_reg};
                par_next = 1'b0;
            end
        end

        if (cmd.chunk)
        begin
            rem_next       = rem_reg - {5'b0, chunk_len};
            par_next       = par_reg ^ chunk_len[0];
            done_next      = count_res[15:0];
            out_valid_next = 1'b1;
            data_next      = chunk_data;
            count_next     = chunk_len;
            last_next      = (rem_reg <= OB9);
            line_next      = count_res[16];
            err_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eb_cfg_reg    <= ELEMENT_BYTES_RESET;
            line_cfg_reg  <= LINE_ELEMENTS_RESET;
            run_reg       <= '0;
            left_reg      <= '0;
            fvb_reg       <= '0;
            val_reg       <= '0;
            done_reg      <= '0;
            rem_reg       <= '0;
            par_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            eb_cfg_reg    <= eb_cfg_next;
            line_cfg_reg  <= line_cfg_next;
            run_reg       <= run_next;
            left_reg      <= left_next;
            fvb_reg       <= fvb_next;
            val_reg       <= val_next;
            done_reg      <= done_next;
            rem_reg       <= rem_next;
            par_reg       <= par_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        count_reg <= count_next;
        last_reg  <= last_next;
        line_reg  <= line_next;
        err_reg   <= err_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = data_reg;
    assign byte_count    = count_reg;
    assign run_last      = last_reg;
    assign line_done     = line_reg;
    assign overrun_error = err_reg;

    `PBRLE_ASSERT_IMPL(a_done_below_line, 1'b1, 17'(done_reg) < line_len, "element count left line")
    `PBRLE_ASSERT_IMPL(a_load_into_free, cmd.hdr_err || cmd.lit_byte || cmd.chunk, out_free, "output register overwritten")
    `PBRLE_ASSERT_NEXT(a_err_beat_empty, cmd.hdr_err, out_valid_reg && err_reg && count_reg == 4'd0 && !line_reg, "bad overrun beat")
    `PBRLE_ASSERT_IMPL(a_chunk_sane, cmd.chunk, chunk_len != 4'd0 && rem_reg <= 9'd256, "empty or oversized burst chunk")

endmodule

>>> sv/packbits_rle_decoder_unit.sv
// a literal byte or an overrun header is on the master side in the cycle after it is accepted
// a repeat value leaves ceil(run bytes / OUT_BYTES) beats, one per cycle unless m_tready holds them;
// the first is loaded into the output register from the burst state that follows its last byte
// throughput: one compressed byte per cycle for headers and literals; the input stalls during a burst
// the single output register sets the pace: a byte that makes a beat waits until the register frees
// reset (rst_n low, asynchronous): header phase, counters zero, element_bytes 1, line_elements 256
module packbits_rle_decoder_unit
    import pbrle_pkg::*;
#(
    parameter int OUT_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // compressed stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte
    // decoded stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // out_data[63:0], byte_count[67:64], zero fill
    output logic        m_tlast,    // run_last
    output logic [1:0]  m_tuser,    // line_done, overrun_error
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    pbrle_cmd_t    cmd;
    pbrle_status_t status;

    logic [63:0] out_data;
    logic [3:0]  byte_count;
    logic        line_done;
    logic        overrun_error;

    // run phase control: header, literal bytes, repeat value, burst out
    pbrle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, line tracking, burst packing and the output register
    pbrle_datapath #(
        .OUT_BYTES (OUT_BYTES)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (s_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_data      (out_data),
        .byte_count    (byte_count),
        .run_last      (m_tlast),
        .line_done     (line_done),
        .overrun_error (overrun_error)
    );

    // pack the beat fields, lowest field first
    assign m_tdata = {4'b0, byte_count, out_data};
    assign m_tuser = {overrun_error, line_done};

endmodule
